// ===== rtl/core/srq_pkg.sv =====
`timescale 1ns / 1ps
package srq_pkg;
    localparam int SAMPLE_W = 16;
    localparam int RES_W = 17;
    localparam int CODE_W = 8;
    localparam int STEP_W = 18;
    localparam int QV_W = 7;
    localparam int RANGE_W = 18;
    localparam logic signed [RES_W-1:0] SIGN_OFFSET = 17'sd1448;
    localparam logic signed [RES_W-1:0] MIN_RESET = 17'sd65535;
    localparam logic signed [RES_W-1:0] MAX_RESET = -17'sd65536;
    localparam logic [QV_W-1:0] Q_MAX = 7'd127;

    // row summary handed from the loader to the emitter
    typedef struct packed {
        logic signed [RES_W-1:0] base;
        logic [RANGE_W-1:0] range;
    } row_info_t;

    function automatic logic signed [RES_W-1:0] residual_of(input logic signed [SAMPLE_W-1:0] y);
        logic signed [RES_W-1:0] ye;
        begin
            ye = RES_W'(y);
            residual_of = y[SAMPLE_W-1] ? ye + SIGN_OFFSET : ye - SIGN_OFFSET;
        end
    endfunction
endpackage

// ===== rtl/core/sign_residual_q7_row_quantizer.sv =====
`timescale 1ns / 1ps
// Sign-residual 7-bit row quantizer.
// s_axis: one transaction carries LANES signed Q2.14 samples of a row.
// m_axis: after ROW_LEN/LANES input transactions the block sends
// ROW_LEN/LANES result transactions, tlast marking the final one.
// After the last input of a row is accepted, the back end computes the
// step by reciprocal multiply, runs the serial division for the
// reciprocal 127/range, then reads, estimates and corrects each group; a
// flat row skips the division. Each result is taken before the next
// group is read, so groups are handled one at a time.
// The front end stores the row and tracks min/max; the back end copies the
// row summary and reads the stored row back. The input is held off from
// the end of a row until its last result leaves, so rows do not overlap.
// A stalled receiver holds the result steady and pauses the back end only.
// Reset clears counters, the min/max trackers and both state machines;
// the row buffer contents are undefined until written.
module sign_residual_q7_row_quantizer #(
    parameter int ROW_LEN = 128,
    parameter int LANES = 4
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // sample_lane0..sample_lane3, 16 bits each
    input  logic [LANES*16-1:0]     s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // code_lane0..3 (8 each), residual_base (17), residual_step (18), pad
    output logic [((LANES*8+35+7)/8)*8-1:0] m_axis_tdata,
    output logic                    m_axis_tlast
);
    localparam int CW = LANES * srq_pkg::CODE_W;
    localparam int OUT_W = ((CW + 35 + 7) / 8) * 8;
    logic row_valid, row_taken, front_ready;
    srq_pkg::row_info_t row_info;
    logic [$clog2(ROW_LEN/LANES)-1:0] rd_addr;
    logic [LANES*srq_pkg::SAMPLE_W-1:0] rd_data;
    logic [CW-1:0] codes;
    logic signed [srq_pkg::RES_W-1:0] base;
    logic [srq_pkg::STEP_W-1:0] step;
    logic busy_reg;

    // hold off a new row until the back end has read the buffer out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (row_taken)
            busy_reg <= 1'b1;
        else if (m_axis_tvalid && m_axis_tready && m_axis_tlast)
            busy_reg <= 1'b0;
    end
    assign s_axis_tready = front_ready && !busy_reg;

    srq_loader #(.ROW_LEN(ROW_LEN), .LANES(LANES)) u_loader (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid && !busy_reg), .in_ready(front_ready),
        .in_data(s_axis_tdata),
        .row_valid(row_valid), .row_taken(row_taken), .row_info(row_info),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    srq_emitter #(.ROW_LEN(ROW_LEN), .LANES(LANES)) u_emitter (
        .clk(clk), .rst_n(rst_n),
        .row_valid(row_valid), .row_taken(row_taken), .row_info(row_info),
        .rd_addr(rd_addr), .rd_data(rd_data),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_codes(codes), .out_min(base), .out_step(step), .out_last(m_axis_tlast)
    );

    assign m_axis_tdata = OUT_W'({step, base, codes});
endmodule

// ===== rtl/core/srq_divider.sv =====
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module srq_divider #(
    parameter int NUM_W = 26,
    parameter int DEN_W = 19
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);
    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W-1:0] r_reg, r_next;
    logic [DEN_W-1:0] d_reg, d_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next, done_reg, done_next;
    logic [DEN_W:0]   trial;

    // shift and trial subtract
    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {r_reg, q_reg[NUM_W-1]};
        if (start)
        begin
            q_next = num;
            r_next = '0;
            d_next = den;
            cnt_next = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = DEN_W'(trial - {1'b0, d_reg});
                q_next = {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                r_next = DEN_W'(trial);
                q_next = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quo = q_reg;
endmodule

// ===== rtl/core/srq_loader.sv =====
`timescale 1ns / 1ps
// front: stores a row and tracks residual min and max
module srq_loader #(
    parameter int ROW_LEN = 128,
    parameter int LANES = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [LANES*srq_pkg::SAMPLE_W-1:0]   in_data,
    output logic                                 row_valid,
    input  logic                                 row_taken,
    output srq_pkg::row_info_t                   row_info,
    input  logic [$clog2(ROW_LEN/LANES)-1:0]     rd_addr,
    output logic [LANES*srq_pkg::SAMPLE_W-1:0]   rd_data
);
    localparam int GROUPS = ROW_LEN / LANES;
    localparam int G_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int W = LANES * srq_pkg::SAMPLE_W;

    logic [W-1:0] mem [GROUPS];
    logic [G_W-1:0] cnt_reg;
    logic full_reg;
    logic signed [srq_pkg::RES_W-1:0] min_reg, max_reg, min_next, max_next;
    logic signed [srq_pkg::RES_W-1:0] e;
    logic acc;

    // the row buffer is held until the back end takes the row summary
    assign in_ready = !full_reg;
    assign acc = in_valid && in_ready;

    always_comb
    begin
        min_next = min_reg;
        max_next = max_reg;
        for (int l = 0; l < LANES; l++)
        begin
            e = srq_pkg::residual_of(in_data[l*srq_pkg::SAMPLE_W +: srq_pkg::SAMPLE_W]);
            if (e < min_next) min_next = e;
            if (e > max_next) max_next = e;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            full_reg <= 1'b0;
            min_reg <= srq_pkg::MIN_RESET;
            max_reg <= srq_pkg::MAX_RESET;
        end
        else if (acc)
        begin
            min_reg <= min_next;
            max_reg <= max_next;
            if (cnt_reg == G_W'(GROUPS - 1))
            begin
                cnt_reg <= '0;
                full_reg <= 1'b1;
            end
            else
                cnt_reg <= cnt_reg + 1'b1;
        end
        else if (row_taken)
        begin
            full_reg <= 1'b0;
            min_reg <= srq_pkg::MIN_RESET;
            max_reg <= srq_pkg::MAX_RESET;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
            mem[cnt_reg] <= in_data;
        rd_data <= mem[rd_addr];
    end

    assign row_valid = full_reg;
    assign row_info.base = min_reg;
    assign row_info.range = srq_pkg::RANGE_W'(max_reg - min_reg);
endmodule

// ===== rtl/core/srq_emitter.sv =====
`timescale 1ns / 1ps
// back: step and reciprocal of range, then one code group at a time, each held until taken
module srq_emitter #(
    parameter int ROW_LEN = 128,
    parameter int LANES = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 row_valid,
    output logic                                 row_taken,
    input  srq_pkg::row_info_t                   row_info,
    output logic [$clog2(ROW_LEN/LANES)-1:0]     rd_addr,
    input  logic [LANES*srq_pkg::SAMPLE_W-1:0]   rd_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [LANES*srq_pkg::CODE_W-1:0]     out_codes,
    output logic signed [srq_pkg::RES_W-1:0]     out_min,
    output logic [srq_pkg::STEP_W-1:0]           out_step,
    output logic                                 out_last
);
    localparam int GROUPS = ROW_LEN / LANES;
    localparam int G_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int NUM_W = 32;
    localparam int DEN_W = 19;
    localparam int RECIP_W = 32;
    localparam int RECIP_FRAC = 25;
    localparam logic [NUM_W-1:0] RECIP_NUM = NUM_W'(srq_pkg::Q_MAX) << RECIP_FRAC;
    // ceil(2^34 / 127), exact floor division by 127 for 26-bit operands
    localparam int STEP_SHIFT = 34;
    localparam logic [27:0] INV_127 = 28'd135274561;
    localparam logic [2:0] S_IDLE = 3'd0, S_STEP = 3'd1, S_RECIP = 3'd2,
        S_READ = 3'd3, S_CALC = 3'd4, S_FIX = 3'd5, S_OUT = 3'd6;

    logic [2:0] state_reg;
    logic signed [srq_pkg::RES_W-1:0] base_reg;
    logic [srq_pkg::RANGE_W-1:0] range_reg;
    logic [srq_pkg::STEP_W-1:0] step_reg;
    logic [G_W-1:0] grp_reg;
    logic [RECIP_W-1:0] recip_reg;
    logic [LANES*srq_pkg::CODE_W-1:0] codes_reg;
    logic last_reg;
    logic [srq_pkg::RANGE_W-1:0] d_reg [LANES];
    logic [srq_pkg::RANGE_W-1:0] d_next [LANES];
    logic [7:0] qe_reg [LANES];
    logic [7:0] qe_next [LANES];
    logic [LANES-1:0] sign_reg, sign_next;
    logic div_start, div_done;
    logic [NUM_W-1:0] div_num, div_quo;
    logic [DEN_W-1:0] div_den;
    logic [LANES*srq_pkg::CODE_W-1:0] codes_next;
    logic [25:0] step_num;
    logic [53:0] step_prod;

    // step = (range*512 + 127) / 254 = (range*256 + 63) / 127
    assign step_num = {range_reg, 8'd63};
    assign step_prod = 54'(step_num) * 54'(INV_127);

    // reciprocal 2^25*127/range
    assign div_den = DEN_W'(range_reg);
    assign div_num = RECIP_NUM;
    assign div_start = (state_reg == S_STEP) && (range_reg != '0);

    srq_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
        .done(div_done), .quo(div_quo)
    );

    // code estimate from the reciprocal, never above the exact value
    always_comb
    begin
        logic signed [srq_pkg::SAMPLE_W-1:0] y;
        logic [50:0] prod;
        sign_next = '0;
        for (int l = 0; l < LANES; l++)
        begin
            y = rd_data[l*srq_pkg::SAMPLE_W +: srq_pkg::SAMPLE_W];
            d_next[l] = srq_pkg::RANGE_W'(srq_pkg::residual_of(y) - base_reg);
            prod = 51'(d_next[l]) * 51'(recip_reg) + (51'(1) << (RECIP_FRAC - 1));
            qe_next[l] = 8'(prod >> RECIP_FRAC);
            sign_next[l] = ~y[srq_pkg::SAMPLE_W-1];
        end
    end

    // exact correction by one, clamp, pack
    always_comb
    begin
        logic [7:0] q;
        logic [27:0] lhs, rhs;
        codes_next = '0;
        for (int l = 0; l < LANES; l++)
        begin
            q = qe_reg[l];
            // q correct iff 2*127*d + range >= 2*range*q, and < 2*range*(q+1)
            lhs = 28'(d_reg[l]) * 28'd254 + 28'(range_reg);
            rhs = 28'(range_reg) * 28'(q) * 28'd2;
            if (lhs < rhs)
                q = q - 1'b1;
            else if (lhs >= rhs + 28'(range_reg) * 28'd2)
                q = q + 1'b1;
            if (q > 8'(srq_pkg::Q_MAX)) q = 8'(srq_pkg::Q_MAX);
            if (range_reg == '0) q = '0;
            codes_next[l*srq_pkg::CODE_W +: srq_pkg::CODE_W] = {q[6:0], sign_reg[l]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            grp_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                    if (row_valid) state_reg <= S_STEP;
                S_STEP:
                    state_reg <= (range_reg == '0) ? S_READ : S_RECIP;
                S_RECIP:
                    if (div_done) state_reg <= S_READ;
                S_READ:
                    state_reg <= S_CALC;
                S_CALC:
                    state_reg <= S_FIX;
                S_FIX:
                    state_reg <= S_OUT;
                S_OUT:
                    if (out_ready)
                    begin
                        grp_reg <= grp_reg + 1'b1;
                        state_reg <= last_reg ? S_IDLE : S_READ;
                        if (last_reg) grp_reg <= '0;
                    end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && row_valid)
        begin
            base_reg <= row_info.base;
            range_reg <= row_info.range;
            recip_reg <= '0;
        end
        if (state_reg == S_STEP)
            step_reg <= srq_pkg::STEP_W'(step_prod >> STEP_SHIFT);
        if (state_reg == S_RECIP && div_done)
            recip_reg <= RECIP_W'(div_quo);
        if (state_reg == S_CALC)
        begin
            d_reg <= d_next;
            qe_reg <= qe_next;
            sign_reg <= sign_next;
        end
        if (state_reg == S_FIX)
        begin
            codes_reg <= codes_next;
            last_reg <= (grp_reg == G_W'(GROUPS - 1));
        end
    end

    // the loader's row buffer is released once the summary is captured
    assign row_taken = (state_reg == S_IDLE) && row_valid;
    assign rd_addr = grp_reg;
    assign out_valid = (state_reg == S_OUT);
    assign out_codes = codes_reg;
    assign out_min = base_reg;
    assign out_step = step_reg;
    assign out_last = last_reg;
endmodule
